/* design/csk_pkg.sv */
`timescale 1ns / 1ps

package csk_pkg;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int ID_W     = 31;
  localparam int ELEM_W   = 16;
  localparam int SCORE_W  = 16;
  localparam int RANK_W   = 6;
  localparam int TOPC_W   = 7;

  // Q1.15 score: fraction bits and root search steps
  localparam int FRAC_W      = 15;
  localparam int SRCH_STEPS  = 16;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_QUERY  = 2'd0,
    KIND_CAND   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [14:0] {
    ST_IDLE      = 15'h0001,
    ST_QACC      = 15'h0002,
    ST_CACC      = 15'h0004,
    ST_SC_START  = 15'h0008,
    ST_MUL_P     = 15'h0010,
    ST_MUL_L     = 15'h0020,
    ST_SR_A      = 15'h0040,
    ST_SR_B      = 15'h0080,
    ST_SC_DONE   = 15'h0100,
    ST_INS_START = 15'h0200,
    ST_INS_TAIL  = 15'h0400,
    ST_INS_STEP  = 15'h0800,
    ST_INS_CMP   = 15'h1000,
    ST_EM_RD     = 15'h2000,
    ST_EM_LD     = 15'h4000
  } state_t;

endpackage

/* design/csk_if.sv */
`timescale 1ns / 1ps

// Input request channel
interface csk_item_if;
  import csk_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ID_W-1:0]     item_id;
  logic signed [ELEM_W-1:0] element;
  logic                last_element;

  modport source (output valid, kind, item_id, element, last_element, input ready);
  modport sink (input valid, kind, item_id, element, last_element, output ready);
endinterface

// Ranked result channel
interface csk_result_if;
  import csk_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ID_W-1:0]      ranked_id;
  logic signed [SCORE_W-1:0] score;
  logic [RANK_W-1:0]    rank;
  logic                 empty_res;
  logic                 last;

  modport source (output valid, ranked_id, score, rank, empty_res, last, input ready);
  modport sink (input valid, ranked_id, score, rank, empty_res, last, output ready);
endinterface

// Register write channel (top_count)
interface csk_cfg_if;
  import csk_pkg::*;
  logic              valid;
  logic              ready;
  logic [TOPC_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* design/csk_ram.sv */
`timescale 1ns / 1ps

module csk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/cosine_similarity_top_k_top.sv */
`timescale 1ns / 1ps

// Cosine similarity top-k search. Load a query vector with kind 0 requests,
// then stream candidate vectors with kind 1 requests; a kind 2 request emits
// the kept list best first (or one empty marker) and clears it, keeping the
// query. Each query or candidate element is accepted, then accumulated
// through the registered query store read. The last element of a candidate
// adds the score: two shift-add multiplies on one shared adder (skipped when
// a norm is zero), then a 16 bit root search, then the tail-first list
// insertion, moving one entry at a time through the list memory port
// (top_count clamped to 1..TOP_K_MAX). A finish emits one result at a time,
// each once the output register has drained. The register write channel is
// ready only while idle. No clearing pass is needed.
module cosine_similarity_top_k_top #(
  parameter int DIM_MAX   = 1024,
  parameter int TOP_K_MAX = 64
) (
  input logic clk,
  input logic rst,
  csk_item_if.sink     items,
  csk_result_if.source results,
  csk_cfg_if.sink      cfg
);
  import csk_pkg::*;

  localparam int IDX_W  = $clog2(DIM_MAX + 1);
  localparam int QA_W   = $clog2(DIM_MAX);
  localparam int NORM_W = 31 + $clog2(DIM_MAX);
  localparam int DOT_W  = NORM_W + 1;
  localparam int PROD_W = 2 * NORM_W;
  localparam int SRCH_W = PROD_W + 2 * FRAC_W + 3;
  localparam int MC_W   = $clog2(NORM_W + 1);
  localparam int BIT_W  = $clog2(SRCH_STEPS);
  localparam int CNT_W  = $clog2(TOP_K_MAX + 1);
  localparam int TK_AW  = (TOP_K_MAX > 1) ? $clog2(TOP_K_MAX) : 1;
  localparam int ENT_W  = ID_W + SCORE_W;

  state_t state;

  // Vector state
  logic [IDX_W-1:0]        element_index;
  logic [IDX_W-1:0]        query_length;
  logic [NORM_W-1:0]       query_norm;
  logic signed [DOT_W-1:0] dot_acc;
  logic [NORM_W-1:0]       cand_norm;
  logic [CNT_W-1:0]        top_filled;
  logic [TOPC_W-1:0]       top_count;

  // Latched request
  logic [ID_W-1:0]          it_id;
  logic signed [ELEM_W-1:0] it_elem;
  logic                     it_last;

  // Shift-add multiplier
  logic [PROD_W-1:0] mul_a;
  logic [NORM_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_acc;
  logic [MC_W-1:0]   mul_cnt;
  logic [PROD_W-1:0] prod_p;
  logic [NORM_W-1:0] abs_dot;
  logic              dot_neg;

  // Root search
  logic [SRCH_W-1:0]  lim;
  logic [SRCH_W-1:0]  s_acc;
  logic [SRCH_W-1:0]  kps;
  logic [SRCH_W-1:0]  ps;
  logic [SRCH_W-1:0]  t_mid;
  logic [SRCH_STEPS-1:0] k_root;
  logic [BIT_W-1:0]   bit_idx;
  logic signed [SCORE_W-1:0] score_new;

  // List insertion and emission
  logic [CNT_W-1:0] ins_i;
  logic [CNT_W-1:0] ins_used;
  logic [CNT_W-1:0] emit_k;
  logic [CNT_W-1:0] emit_n;

  // Output register
  logic                      o_valid;
  logic [ID_W-1:0]           o_id;
  logic signed [SCORE_W-1:0] o_score;
  logic [RANK_W-1:0]         o_rank;
  logic                      o_empty;
  logic                      o_last;

  // Memory ports
  logic                q_we;
  logic [QA_W-1:0]     q_addr;
  logic [ELEM_W-1:0]   q_rdata;
  logic                tk_we;
  logic [TK_AW-1:0]    tk_waddr;
  logic [ENT_W-1:0]    tk_wdata;
  logic [TK_AW-1:0]    tk_raddr;
  logic [ENT_W-1:0]    tk_rdata;

  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] used_inc;
  logic signed [2*ELEM_W-1:0] e_sq;
  logic signed [2*ELEM_W-1:0] e_dot;
  logic signed [ELEM_W-1:0]   q_elem;
  logic signed [SCORE_W-1:0]  tk_rd_score;
  logic [ID_W-1:0]            tk_rd_id;
  logic [PROD_W-1:0] mul_sum;
  logic [SRCH_W-1:0] srch_t;
  logic              srch_fit;
  logic [SRCH_W-1:0] kps_upd;
  logic              in_acc;

  assign in_acc = items.valid && items.ready;
  assign items.ready = (state == ST_IDLE);
  assign cfg.ready = (state == ST_IDLE);

  assign results.valid     = o_valid;
  assign results.ranked_id = o_id;
  assign results.score     = o_score;
  assign results.rank      = o_rank;
  assign results.empty_res = o_empty;
  assign results.last      = o_last;

  // List capacity and fill
  always_comb begin
    if (top_count == '0) begin
      cap = CNT_W'(1);
    end else if (top_count > TOPC_W'(TOP_K_MAX)) begin
      cap = CNT_W'(TOP_K_MAX);
    end else begin
      cap = CNT_W'(top_count);
    end
    used = (top_filled < cap) ? top_filled : cap;
    used_inc = (used < cap) ? used + CNT_W'(1) : cap;
  end

  // Element products
  assign q_elem = $signed(q_rdata);
  assign e_sq   = it_elem * it_elem;
  assign e_dot  = it_elem * q_elem;

  // Adder shared by both multiplies, and separate root search adders
  assign mul_sum  = mul_acc + (mul_b[0] ? mul_a : '0);
  assign srch_t   = t_mid + ps;
  assign srch_fit = (srch_t <= lim);
  assign kps_upd  = srch_fit ? kps + (ps << 1) : kps;

  assign tk_rd_score = $signed(tk_rdata[SCORE_W-1:0]);
  assign tk_rd_id    = tk_rdata[ENT_W-1:SCORE_W];

  // Query store port
  assign q_addr = element_index[QA_W-1:0];
  assign q_we   = (state == ST_QACC) && (element_index < IDX_W'(DIM_MAX));

  // List memory ports
  always_comb begin
    tk_we    = 1'b0;
    tk_waddr = ins_i[TK_AW-1:0];
    tk_wdata = {it_id, score_new};
    tk_raddr = '0;
    case (state)
      ST_INS_START: tk_raddr = TK_AW'(cap - CNT_W'(1));
      ST_INS_STEP: begin
        tk_raddr = TK_AW'(ins_i - CNT_W'(1));
        tk_we    = (ins_i == '0);
      end
      ST_INS_CMP: begin
        tk_we = 1'b1;
        if (tk_rd_score < score_new) begin
          tk_wdata = tk_rdata;
        end
      end
      ST_EM_RD: tk_raddr = emit_k[TK_AW-1:0];
      default: ;
    endcase
  end

  csk_ram #(.WIDTH(ELEM_W), .DEPTH(DIM_MAX), .ADDR_W(QA_W)) u_query_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_addr),
    .wdata (it_elem),
    .raddr (q_addr),
    .rdata (q_rdata)
  );

  csk_ram #(.WIDTH(ENT_W), .DEPTH(TOP_K_MAX), .ADDR_W(TK_AW)) u_list_ram (
    .clk   (clk),
    .we    (tk_we),
    .waddr (tk_waddr),
    .wdata (tk_wdata),
    .raddr (tk_raddr),
    .rdata (tk_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      element_index <= '0;
      query_length  <= '0;
      query_norm    <= '0;
      dot_acc       <= '0;
      cand_norm     <= '0;
      top_filled    <= '0;
      top_count     <= TOPC_W'(1);
      o_valid       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        top_count <= cfg.data;
      end
      if (results.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            it_id   <= items.item_id;
            it_elem <= items.element;
            it_last <= items.last_element;
            case (items.kind)
              KIND_QUERY: state <= ST_QACC;
              KIND_CAND:  state <= ST_CACC;
              KIND_FINISH: begin
                emit_n        <= used;
                emit_k        <= '0;
                top_filled    <= '0;
                element_index <= '0;
                dot_acc       <= '0;
                cand_norm     <= '0;
                state         <= ST_EM_RD;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end

        // Query element: store and add to the norm
        ST_QACC: begin
          logic [NORM_W-1:0] qn_base;
          logic [IDX_W-1:0]  idx_new;
          qn_base = (element_index == '0) ? '0 : query_norm;
          idx_new = element_index;
          if (element_index == '0) begin
            query_length <= '0;
          end
          if (element_index < IDX_W'(DIM_MAX)) begin
            qn_base = qn_base + NORM_W'($unsigned(e_sq));
            idx_new = element_index + IDX_W'(1);
          end
          query_norm <= qn_base;
          if (it_last) begin
            query_length  <= idx_new;
            element_index <= '0;
            dot_acc       <= '0;
            cand_norm     <= '0;
          end else begin
            element_index <= idx_new;
          end
          state <= ST_IDLE;
        end

        // Candidate element: accumulate against the stored query element
        ST_CACC: begin
          if (element_index < query_length && element_index < IDX_W'(DIM_MAX)) begin
            dot_acc   <= dot_acc + DOT_W'(e_dot);
            cand_norm <= cand_norm + NORM_W'($unsigned(e_sq));
          end
          if (it_last) begin
            element_index <= '0;
            state         <= ST_SC_START;
          end else begin
            if (element_index < IDX_W'(DIM_MAX)) begin
              element_index <= element_index + IDX_W'(1);
            end
            state <= ST_IDLE;
          end
        end

        ST_SC_START: begin
          dot_neg <= dot_acc[DOT_W-1];
          abs_dot <= dot_acc[DOT_W-1] ? NORM_W'(-dot_acc) : NORM_W'(dot_acc);
          if (query_norm == '0 || cand_norm == '0) begin
            score_new <= '0;
            state     <= ST_INS_START;
          end else begin
            mul_a   <= PROD_W'(query_norm);
            mul_b   <= cand_norm;
            mul_acc <= '0;
            mul_cnt <= MC_W'(NORM_W);
            state   <= ST_MUL_P;
          end
        end

        // Product of the norms
        ST_MUL_P: begin
          mul_a   <= mul_a << 1;
          mul_b   <= mul_b >> 1;
          mul_acc <= mul_sum;
          mul_cnt <= mul_cnt - MC_W'(1);
          if (mul_cnt == MC_W'(1)) begin
            prod_p  <= mul_sum;
            mul_a   <= PROD_W'(abs_dot);
            mul_b   <= abs_dot;
            mul_acc <= '0;
            mul_cnt <= MC_W'(NORM_W);
            state   <= ST_MUL_L;
          end
        end

        // Square of the dot magnitude
        ST_MUL_L: begin
          mul_a   <= mul_a << 1;
          mul_b   <= mul_b >> 1;
          mul_acc <= mul_sum;
          mul_cnt <= mul_cnt - MC_W'(1);
          if (mul_cnt == MC_W'(1)) begin
            lim     <= SRCH_W'(mul_sum) << (2 * FRAC_W);
            ps      <= SRCH_W'(prod_p) << (2 * (SRCH_STEPS - 1));
            kps     <= '0;
            s_acc   <= '0;
            k_root  <= '0;
            bit_idx <= BIT_W'(SRCH_STEPS - 1);
            state   <= ST_SR_A;
          end
        end

        // Root search, one result bit per pass through ST_SR_A and ST_SR_B:
        // test (k + 2^b)^2 * P against dot^2 * 2^30
        ST_SR_A: begin
          t_mid <= s_acc + kps;
          state <= ST_SR_B;
        end

        ST_SR_B: begin
          if (srch_fit) begin
            s_acc  <= srch_t;
            k_root <= k_root | (SRCH_STEPS'(1) << bit_idx);
          end
          kps <= kps_upd >> 1;
          ps  <= ps >> 2;
          if (bit_idx == '0) begin
            state <= ST_SC_DONE;
          end else begin
            bit_idx <= bit_idx - BIT_W'(1);
            state   <= ST_SR_A;
          end
        end

        // Sign and saturate; a root at or above unit magnitude pins to full scale
        ST_SC_DONE: begin
          if (dot_neg) begin
            if (k_root[SRCH_STEPS-1]) begin
              score_new <= {1'b1, {(SCORE_W-1){1'b0}}};
            end else begin
              score_new <= $signed(-k_root);
            end
          end else if (k_root > SRCH_STEPS'(32767)) begin
            score_new <= SCORE_W'(32767);
          end else begin
            score_new <= $signed(k_root);
          end
          state <= ST_INS_START;
        end

        // Insertion from the tail; a full list first checks its last entry
        ST_INS_START: begin
          ins_used <= used;
          if (used == cap) begin
            state <= ST_INS_TAIL;
          end else begin
            ins_i <= used;
            state <= ST_INS_STEP;
          end
        end

        ST_INS_TAIL: begin
          if (tk_rd_score >= score_new) begin
            top_filled <= ins_used;
            dot_acc    <= '0;
            cand_norm  <= '0;
            state      <= ST_IDLE;
          end else begin
            ins_i <= cap - CNT_W'(1);
            state <= ST_INS_STEP;
          end
        end

        ST_INS_STEP: begin
          if (ins_i == '0) begin
            top_filled <= used_inc;
            dot_acc    <= '0;
            cand_norm  <= '0;
            state      <= ST_IDLE;
          end else begin
            state <= ST_INS_CMP;
          end
        end

        ST_INS_CMP: begin
          if (tk_rd_score >= score_new) begin
            top_filled <= used_inc;
            dot_acc    <= '0;
            cand_norm  <= '0;
            state      <= ST_IDLE;
          end else begin
            ins_i <= ins_i - CNT_W'(1);
            state <= ST_INS_STEP;
          end
        end

        // Emission, one entry per read
        ST_EM_RD: begin
          if (!o_valid) begin
            if (emit_n == '0) begin
              o_valid <= 1'b1;
              o_id    <= '0;
              o_score <= '0;
              o_rank  <= '0;
              o_empty <= 1'b1;
              o_last  <= 1'b1;
              state   <= ST_IDLE;
            end else begin
              state <= ST_EM_LD;
            end
          end
        end

        ST_EM_LD: begin
          o_valid <= 1'b1;
          o_id    <= tk_rd_id;
          o_score <= tk_rd_score;
          o_rank  <= RANK_W'(emit_k);
          o_empty <= 1'b0;
          o_last  <= (emit_k == emit_n - CNT_W'(1));
          emit_k  <= emit_k + CNT_W'(1);
          if (emit_k == emit_n - CNT_W'(1)) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_EM_RD;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_finish_emits: assert property (@(posedge clk) disable iff (rst)
    (in_acc && items.kind == KIND_FINISH) |=> (state == ST_EM_RD && top_filled == '0))
    else $error("finish did not start emission");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |=>
      (results.valid && $stable(results.ranked_id) && $stable(results.score) &&
       $stable(results.rank) && $stable(results.empty_res) && $stable(results.last)))
    else $error("waiting result changed");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    top_filled <= CNT_W'(TOP_K_MAX))
    else $error("list fill beyond capacity");

  a_qlen_bound: assert property (@(posedge clk) disable iff (rst)
    (query_length <= IDX_W'(DIM_MAX)) && (element_index <= IDX_W'(DIM_MAX)))
    else $error("vector position beyond store depth");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import csk_pkg::*;

  localparam int DIM        = 1024;
  localparam int KEEP_MAX   = 64;
  localparam int SETTLE     = 400;
  localparam longint LIMIT  = 3000000;

  typedef struct {
    logic [ID_W-1:0]           ranked_id;
    logic signed [SCORE_W-1:0] score;
    logic [RANK_W-1:0]         rank;
    logic                      empty_res;
    logic                      last;
  } ranked_t;

  // Scoreboard: keeps its own copy of the search state and the ranked list
  class rank_board;
    shortint          qstore[DIM];
    int unsigned      qlen, eidx, filled, topc, qwritten;
    longint unsigned  qnorm, cnorm;
    longint           dot;
    logic [ID_W-1:0]  ids[KEEP_MAX];
    shortint          scores[KEEP_MAX];
    ranked_t          pending[$];
    int               errors, mismatches, seen, requests, finishes;

    function new();
      qlen = 0; eidx = 0; filled = 0; topc = 1; qwritten = 0;
      qnorm = 0; cnorm = 0; dot = 0;
      errors = 0; mismatches = 0; seen = 0; requests = 0; finishes = 0;
    endfunction

    function void set_top_count(logic [TOPC_W-1:0] v);
      topc = v;
    endfunction

    function int unsigned keep_cap();
      if (topc < 1) return 1;
      if (topc > KEEP_MAX) return KEEP_MAX;
      return topc;
    endfunction

    // floor(|dot| * 2^15 / sqrt(qn * cn)) by search on the squared form
    function shortint cosine_q15();
      logic [127:0]    lim, prod, t;
      longint unsigned ad;
      int unsigned     lo, hi, mid;
      if (qnorm == 0 || cnorm == 0) return 0;
      ad = dot < 0 ? longint'(-dot) : longint'(dot);
      lim = (128'(ad) * 128'(ad)) << 30;
      prod = 128'(qnorm) * 128'(cnorm);
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t = prod * 128'(mid * mid);
        if (t <= lim) lo = mid;
        else hi = mid - 1;
      end
      if (dot < 0) return shortint'(-int'(lo));
      return lo > 32767 ? 16'sd32767 : shortint'(lo);
    endfunction

    // Sorted insert; equal scores keep the earlier item ahead
    function void insert_ranked(logic [ID_W-1:0] id, shortint sc);
      int unsigned cap, used, pos, i;
      cap = keep_cap();
      used = filled < cap ? filled : cap;
      pos = 0;
      while (pos < used && scores[pos] >= sc) pos++;
      if (pos >= cap) begin
        filled = used;
        return;
      end
      i = used < cap ? used : cap - 1;
      for (; i > pos; i--) begin
        ids[i] = ids[i-1];
        scores[i] = scores[i-1];
      end
      ids[pos] = id;
      scores[pos] = sc;
      filled = used + 1 < cap ? used + 1 : cap;
    endfunction

    function void clear_cand();
      eidx = 0; dot = 0; cnorm = 0;
    endfunction

    // Accepted request: advance state, queue the results it causes
    function void note_request(kind_t kind, logic [ID_W-1:0] id,
                               shortint e, logic lst);
      int unsigned n;
      ranked_t r;
      requests++;
      case (kind)
        KIND_QUERY: begin
          if (eidx == 0) begin
            qlen = 0; qnorm = 0;
          end
          if (eidx < DIM) begin
            qstore[eidx] = e;
            qnorm += longint'(longint'(e) * e);
            eidx++;
            if (eidx > qwritten) qwritten = eidx;
          end
          if (lst) begin
            qlen = eidx;
            clear_cand();
          end
        end
        KIND_CAND: begin
          if (eidx < qlen && eidx < DIM) begin
            dot += longint'(e) * qstore[eidx];
            cnorm += longint'(longint'(e) * e);
          end
          if (eidx < DIM) eidx++;
          if (lst) begin
            insert_ranked(id, cosine_q15());
            clear_cand();
          end
        end
        KIND_FINISH: begin
          finishes++;
          n = filled < keep_cap() ? filled : keep_cap();
          if (n == 0) begin
            r = '{ranked_id: '0, score: '0, rank: '0, empty_res: 1'b1, last: 1'b1};
            pending.insert(pending.size(), r);
          end
          for (int k = 0; k < n; k++) begin
            r = '{ranked_id: ids[k], score: scores[k], rank: k[RANK_W-1:0],
                  empty_res: 1'b0, last: (k + 1 == n)};
            pending.insert(pending.size(), r);
          end
          filled = 0;
          clear_cand();
        end
        default: ;
      endcase
    endfunction

    function void check_result(ranked_t a);
      ranked_t x;
      seen++;
      if (pending.size() == 0) begin
        errors++;
        if (++mismatches <= 10)
          $display("unexpected result id=%0d score=%0d rank=%0d", a.ranked_id,
                   a.score, a.rank);
        return;
      end
      x = pending.pop_front();
      if (a.ranked_id !== x.ranked_id || a.score !== x.score || a.rank !== x.rank ||
          a.empty_res !== x.empty_res || a.last !== x.last) begin
        errors++;
        if (++mismatches <= 10)
          $display({"mismatch: exp id=%0d sc=%0d rk=%0d em=%0b l=%0b, ",
                    "got id=%0d sc=%0d rk=%0d em=%0b l=%0b"},
                   x.ranked_id, x.score, x.rank, x.empty_res, x.last,
                   a.ranked_id, a.score, a.rank, a.empty_res, a.last);
      end
    endfunction

    function void close();
      if (pending.size() != 0) begin
        errors++;
        $display("%0d expected results never arrived", pending.size());
      end
    endfunction
  endclass

  logic clk, rst;
  csk_item_if   items_if();
  csk_result_if res_if();
  csk_cfg_if    cfg_if();

  cosine_similarity_top_k_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  rank_board sb = new();
  longint cycles = 0;
  bit no_gaps = 0;
  int cfg_writes = 0;
  int tb_qlen = 1;
  shortint cand_prev[$];
  logic [TOPC_W-1:0] list_sizes[6] = '{7'd3, 7'd1, 7'd0, 7'd127, 7'd2, 7'd5};

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    ranked_t a;
    if (!rst && res_if.valid && res_if.ready) begin
      a = '{ranked_id: res_if.ranked_id, score: res_if.score, rank: res_if.rank,
            empty_res: res_if.empty_res, last: res_if.last};
      sb.check_result(a);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stalls: short and long holds, with stall-free stretches
  int hold = 0;
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      hold <= pick_gap();
    end
  end

  // A query element that would leave a gap of unwritten store entries is sent as kind 3
  task automatic send_req(kind_t kind, logic [ID_W-1:0] id, shortint e, logic lst);
    int gap;
    kind_t k;
    k = kind;
    if (k == KIND_QUERY && sb.eidx > sb.qwritten) k = KIND_NONE;
    gap = pick_gap();
    if (gap > 0) begin
      items_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_if.valid = 1'b1;
    items_if.kind = k;
    items_if.item_id = id;
    items_if.element = e;
    items_if.last_element = lst;
    do @(posedge clk); while (!items_if.ready);
    sb.note_request(k, id, e, lst);
    @(negedge clk);
  endtask

  task automatic write_top_count(logic [TOPC_W-1:0] v);
    items_if.valid = 1'b0;
    cfg_if.valid = 1'b1;
    cfg_if.data = v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_top_count(v);
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_idle();
    items_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic shortint rand_elem();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return -16'sd32768;
    if (r < 10) return 16'sd32767;
    if (r < 13) return 0;
    if (r < 15) return -1;
    return shortint'($urandom);
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom);
  endfunction

  task automatic send_query(int len, shortint fixed, bit use_fixed);
    for (int i = 0; i < len; i++)
      send_req(KIND_QUERY, rand_id(), use_fixed ? fixed : rand_elem(), i == len - 1);
    tb_qlen = len > DIM ? DIM : len;
  endtask

  // One candidate; mode picks the content style
  task automatic send_cand(int len, int mode, logic [ID_W-1:0] id);
    shortint v[$];
    shortint e;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: e = rand_elem();
        1: e = (i < tb_qlen) ? sb.qstore[i] : rand_elem();
        2: e = (i < tb_qlen) ? shortint'(-int'(sb.qstore[i])) : 0;
        3: e = 0;
        default: e = (i < cand_prev.size()) ? cand_prev[i] : rand_elem();
      endcase
      v.insert(v.size(), e);
      send_req(KIND_CAND, (i == len - 1) ? id : rand_id(), e, i == len - 1);
    end
    cand_prev = v;
  endtask

  // Random stream of well-formed sequences with some noise mixed in
  task automatic random_phase(int budget);
    int start, r, len;
    start = sb.requests;
    while (sb.requests - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_query($urandom_range(0, 3) == 0 ? $urandom_range(8, 16) : $urandom_range(1, 6),
                   0, 0);
      end else if (r < 75) begin
        len = tb_qlen + $urandom_range(0, 4) - 2;
        if (len < 1) len = 1;
        send_cand(len, $urandom_range(0, 4), rand_id());
      end else if (r < 87) begin
        send_req(KIND_FINISH, rand_id(), rand_elem(), $urandom_range(0, 1));
      end else begin
        send_req(kind_t'($urandom_range(0, 3)), rand_id(), rand_elem(),
                 $urandom_range(0, 1));
      end
      if (r == 50) begin
        items_if.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
    end
    send_req(KIND_FINISH, 0, 0, 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.kind = KIND_QUERY;
    items_if.item_id = '0;
    items_if.element = '0;
    items_if.last_element = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: empty list, extremes, saturation both ways, zero norm,
    // long and short candidates, ties, ignored kind, mid-query candidate
    write_top_count(7'd64);
    no_gaps = 1;
    send_req(KIND_FINISH, 0, 0, 1'b1);
    send_req(KIND_CAND, 31'h7fff_ffff, 16'sd5, 1'b1);
    send_query(3, 0, 0);
    send_req(KIND_NONE, rand_id(), 16'sd7, 1'b1);
    send_cand(3, 1, 31'h7fff_ffff);
    send_cand(3, 2, 31'd0);
    send_cand(3, 3, 31'd11);
    send_cand(5, 0, 31'd12);
    send_cand(1, 4, 31'd13);
    send_cand(1, 4, 31'd14);
    no_gaps = 0;
    send_req(KIND_FINISH, 0, 0, 1'b0);
    send_query(2, -16'sd32768, 1);
    send_req(KIND_QUERY, 1, 16'sd32767, 1'b0);
    send_req(KIND_CAND, 2, 16'sd32767, 1'b1);
    send_req(KIND_QUERY, 3, -16'sd1, 1'b1);
    tb_qlen = 2;
    send_cand(2, 1, 31'h5555_5555);
    send_req(KIND_FINISH, 0, 0, 1'b1);
    wait_idle();

    // Random traffic across several list sizes, extremes included
    foreach (list_sizes[i]) begin
      write_top_count(list_sizes[i]);
      random_phase(i == 0 ? 16 : 5);
      wait_idle();
    end

    // A long ranked run at the largest list size
    write_top_count(7'd64);
    send_query(2, 0, 0);
    for (int i = 0; i < 16; i++) send_cand(2, 0, rand_id());
    send_req(KIND_FINISH, 0, 0, 1'b0);
    wait_idle();

    sb.close();
    $display("%0d requests in, %0d results checked, %0d finish requests, %0d list sizes",
             sb.requests, sb.seen, sb.finishes, cfg_writes);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("%0d failures", sb.errors);
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* cosine_similarity_top_k_top.f */
design/csk_pkg.sv
design/csk_if.sv
design/csk_ram.sv
design/cosine_similarity_top_k_top.sv
verif/tb_top.sv
